### hw/rtl/baro_pkg.sv
`timescale 1ns / 1ps
package baro_pkg;

    localparam int TEMP_FRAC_BITS = 24;
    localparam int PRES_FRAC_BITS = 7;
    localparam int TQ_BITS        = 20;
    localparam int PSCALE         = 97;
    localparam int ACC_W          = 128;
    localparam int PIPE_STAGES    = 7;

    localparam logic [1:0] REG_TRIM_LOW  = 2'd0;
    localparam logic [1:0] REG_TRIM_MID  = 2'd1;
    localparam logic [1:0] REG_TRIM_HIGH = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [23:0] raw_temp;
        logic [23:0] raw_pres;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] temperature;
        logic [23:0]        pressure;
        logic               pressure_valid;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [7:0]  t3;
        logic signed [16:0] p1m;
        logic signed [16:0] p2m;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic [15:0]        p5;
        logic [15:0]        p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } t_trim;

endpackage

### hw/rtl/baro_pres_pipe.sv
`timescale 1ns / 1ps
module baro_pres_pipe (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [27:0]    i_t,
    input  logic [23:0]           i_p,
    input  baro_pkg::t_trim       i_trim,
    output logic                  o_valid,
    output logic [23:0]           o_pres,
    output logic                  o_sat
);
    import baro_pkg::*;

    localparam int S = PSCALE - PRES_FRAC_BITS;

    logic [PIPE_STAGES-1:0] r_v;

    // stage 1: input register
    logic signed [27:0] r1_t;
    logic signed [24:0] r1_p;

    // stage 2: innermost Horner steps in t; P^3 term folded into the P^2 factor
    logic signed [27:0] r2_t;
    logic signed [24:0] r2_p;
    logic signed [36:0] r2_a;
    logic signed [36:0] r2_b;
    logic signed [37:0] r2_c;

    // stage 3: second Horner step, P times the P^2 factor
    logic signed [27:0] r3_t;
    logic signed [24:0] r3_p;
    logic signed [66:0] r3_a;
    logic signed [66:0] r3_b;
    logic signed [60:0] r3_c;

    // stage 4: last products by t, split in two limbs
    logic signed [24:0] r4_p;
    logic signed [60:0] r4_c;
    logic signed [60:0] r4_al, r4_bl;
    logic signed [62:0] r4_ah, r4_bh;

    // stage 5: limb sums
    logic signed [24:0] r5_p;
    logic signed [95:0] r5_a, r5_b;

    // stage 6: P times the P polynomial, split in three limbs
    logic signed [95:0] r6_a;
    logic signed [57:0] r6_m0, r6_m1, r6_m2;

    // stage 7: accumulate and round
    logic signed [ACC_W-1:0] r7_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[PIPE_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_t <= i_t;
        r1_p <= $signed({1'b0, i_p});

        r2_t <= r1_t;
        r2_p <= r1_p;
        r2_a <= 37'(i_trim.p8) * 37'(r1_t) + (37'(i_trim.p7) <<< 27);
        r2_b <= 37'(i_trim.p4) * 37'(r1_t) + (37'(i_trim.p3) <<< 25);
        r2_c <= 38'(i_trim.p10) * 38'(r1_t) + (38'(i_trim.p9) <<< 20)
              + ((38'(i_trim.p11) * 38'(r1_p)) <<< 3);

        r3_t <= r2_t;
        r3_p <= r2_p;
        r3_a <= 67'(r2_a) * 67'(r2_t) + (67'($signed({1'b0, i_trim.p6})) <<< 49);
        r3_b <= 67'(r2_b) * 67'(r2_t) + (67'(i_trim.p2m) <<< 48);
        r3_c <= 61'(r2_c) * 61'(r2_p);

        r4_p  <= r3_p;
        r4_c  <= r3_c;
        r4_al <= 61'($signed({1'b0, r3_a[31:0]})) * 61'(r3_t);
        r4_ah <= 63'($signed(r3_a[66:32])) * 63'(r3_t);
        r4_bl <= 61'($signed({1'b0, r3_b[31:0]})) * 61'(r3_t);
        r4_bh <= 63'($signed(r3_b[66:32])) * 63'(r3_t);

        r5_p <= r4_p;
        r5_a <= (96'(r4_ah) <<< 32) + 96'(r4_al)
              + (96'($signed({1'b0, i_trim.p5})) <<< 78);
        r5_b <= (96'(r4_bh) <<< 32) + 96'(r4_bl)
              + (96'(i_trim.p1m) <<< 77) + (96'(r4_c) <<< 29);

        r6_a  <= r5_a;
        r6_m0 <= 58'($signed({1'b0, r5_b[31:0]})) * 58'(r5_p);
        r6_m1 <= 58'($signed({1'b0, r5_b[63:32]})) * 58'(r5_p);
        r6_m2 <= 58'($signed(r5_b[95:64])) * 58'(r5_p);

        r7_acc <= (ACC_W'(r6_a) <<< 22) + (ACC_W'(r6_m2) <<< 64)
                + (ACC_W'(r6_m1) <<< 32) + ACC_W'(r6_m0) + (ACC_W'(1) <<< (S - 1));
    end

    logic signed [ACC_W-1:0] w_sh;
    assign w_sh = r7_acc >>> S;

    always_comb begin
        o_valid = r_v[PIPE_STAGES-1];
        o_sat   = 1'b0;
        o_pres  = w_sh[23:0];
        if (w_sh[ACC_W-1]) begin
            o_pres = '0;
            o_sat  = 1'b1;
        end else if (w_sh[ACC_W-2:24] != '0) begin
            o_pres = '1;
            o_sat  = 1'b1;
        end
    end

endmodule

### hw/rtl/baro_temp_pressure_compensation_unit.sv
`timescale 1ns / 1ps
// Between the start cycle and o_done lie two temperature stages, the seven-stage
// pressure pipeline and an output register.
// Throughput: one transaction per cycle; busy is always low.
// Reset: synchronous active-low i_rst_n clears trim registers and valid bits.
// The receiver cannot stall; each result is shown for one cycle.
module baro_temp_pressure_compensation_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  baro_pkg::t_in_item  i_item,
    output logic                o_done,
    output baro_pkg::t_out_item o_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    import baro_pkg::*;

    logic [63:0] r_tw0, r_tw1;
    logic [39:0] r_tw2;
    logic [1:0]  w_idx;
    t_trim       w_trim;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign w_idx  = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tw0 <= '0;
            r_tw1 <= '0;
            r_tw2 <= '0;
        end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
            unique case (w_idx)
                REG_TRIM_LOW:  r_tw0 <= pwdata;
                REG_TRIM_MID:  r_tw1 <= pwdata;
                REG_TRIM_HIGH: r_tw2 <= pwdata[39:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TRIM_LOW:  prdata = r_tw0;
            REG_TRIM_MID:  prdata = r_tw1;
            REG_TRIM_HIGH: prdata = {24'd0, r_tw2};
            default:       prdata = '0;
        endcase
    end

    logic [167:0] w_b;
    assign w_b = {r_tw2, r_tw1, r_tw0};
    always_comb begin
        w_trim.t1  = w_b[15:0];
        w_trim.t2  = w_b[31:16];
        w_trim.t3  = w_b[39:32];
        w_trim.p1m = $signed({w_b[55], w_b[55:40]}) - 17'sd16384;
        w_trim.p2m = $signed({w_b[71], w_b[71:56]}) - 17'sd16384;
        w_trim.p3  = w_b[79:72];
        w_trim.p4  = w_b[87:80];
        w_trim.p5  = w_b[103:88];
        w_trim.p6  = w_b[119:104];
        w_trim.p7  = w_b[127:120];
        w_trim.p8  = w_b[135:128];
        w_trim.p9  = w_b[151:136];
        w_trim.p10 = w_b[159:152];
        w_trim.p11 = w_b[167:160];
    end

    // temperature stages
    logic [1:0]         r_tv;
    t_in_item           r1_in, r2_in;
    logic signed [51:0] r1_dd;
    logic signed [41:0] r1_dt2;
    logic signed [63:0] r2_t48;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= '0;
        end else begin
            r_tv <= {r_tv[0], start};
        end
    end

    logic signed [25:0] w_d;
    assign w_d = $signed({2'b0, i_item.raw_temp}) - $signed({2'b0, w_trim.t1, 8'd0});

    always_ff @(posedge i_clk) begin
        r1_in  <= i_item;
        r1_dd  <= w_d * w_d;
        r1_dt2 <= w_d * w_trim.t2;
        r2_in  <= r1_in;
        r2_t48 <= (64'(r1_dt2) <<< 18) + 64'(r1_dd) * 64'(w_trim.t3);
    end

    logic signed [63:0] w_tr, w_tq;
    logic signed [31:0] w_temp;
    logic               w_tsat, w_csat;
    logic signed [27:0] w_tc;
    assign w_tr = (r2_t48 + (64'sd1 <<< (47 - TEMP_FRAC_BITS))) >>> (48 - TEMP_FRAC_BITS);
    assign w_tq = (r2_t48 + (64'sd1 <<< (47 - TQ_BITS))) >>> (48 - TQ_BITS);

    always_comb begin
        w_tsat = 1'b0;
        w_temp = w_tr[31:0];
        if (w_tr > 64'sd2147483647) begin
            w_temp = 32'sh7fffffff;
            w_tsat = 1'b1;
        end else if (w_tr < -64'sd2147483648) begin
            w_temp = 32'sh80000000;
            w_tsat = 1'b1;
        end
        w_csat = 1'b0;
        w_tc   = w_tq[27:0];
        if (w_tq > 64'sd134217727) begin
            w_tc = 28'sh7ffffff;
            w_csat = 1'b1;
        end else if (w_tq < -64'sd134217728) begin
            w_tc = 28'sh8000000;
            w_csat = 1'b1;
        end
    end

    // delay temperature results alongside pressure pipe
    logic signed [31:0]     r_dt [0:PIPE_STAGES-1];
    logic [PIPE_STAGES-1:0] r_dk, r_ds;

    always_ff @(posedge i_clk) begin
        r_dt[0] <= w_temp;
        r_dk[0] <= r2_in.kind;
        r_ds[0] <= w_tsat | (r2_in.kind & w_csat);
        for (int k = 1; k < PIPE_STAGES; k++) begin
            r_dt[k] <= r_dt[k-1];
        end
        r_dk[PIPE_STAGES-1:1] <= r_dk[PIPE_STAGES-2:0];
        r_ds[PIPE_STAGES-1:1] <= r_ds[PIPE_STAGES-2:0];
    end

    logic        w_pv, w_psat;
    logic [23:0] w_pres;

    baro_pres_pipe u_pres (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_tv[1]),
        .i_t     (w_tc),
        .i_p     (r2_in.raw_pres),
        .i_trim  (w_trim),
        .o_valid (w_pv),
        .o_pres  (w_pres),
        .o_sat   (w_psat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= w_pv;
        end
        o_item.temperature    <= r_dt[PIPE_STAGES-1];
        o_item.pressure       <= r_dk[PIPE_STAGES-1] ? w_pres : 24'd0;
        o_item.pressure_valid <= r_dk[PIPE_STAGES-1];
        o_item.saturated      <= r_ds[PIPE_STAGES-1] | (r_dk[PIPE_STAGES-1] & w_psat);
    end

    a_busy: assert property (@(posedge i_clk) !busy) else $error("busy high");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_pv) == o_done || !$past(i_rst_n)) else $error("done timing");
    a_pv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_item.pressure_valid |-> o_item.pressure == 24'd0)
        else $error("pressure not zero");

endmodule
